// ----- sv/ctsc_pkg.sv -----
// ----------------------------------------------------------------------------
// ctsc_pkg
// Shared types, constants and helper functions of the clock time-set
// controller.
// ----------------------------------------------------------------------------
package ctsc_pkg;

  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned PERIOD_W = 10;
  localparam int unsigned HOLD_W   = 11;
  localparam int unsigned INDEX_W  = 2;
  localparam int unsigned POS_W    = 2;
  localparam int unsigned HOURS_W  = 5;
  localparam int unsigned MIN_W    = 6;

  localparam logic [OPCODE_W-1:0] OP_TICK  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_OK    = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_UP    = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_DOWN  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_PULSE = 3'd4;

  localparam logic [INDEX_W-1:0] REG_BLINK_PERIOD  = 2'd0;
  localparam logic [INDEX_W-1:0] REG_HOLD_DELAY    = 2'd1;
  localparam logic [INDEX_W-1:0] REG_REPEAT_PERIOD = 2'd2;

  localparam logic [POS_W-1:0] POS_NONE    = 2'd0;
  localparam logic [POS_W-1:0] POS_HOURS   = 2'd1;
  localparam logic [POS_W-1:0] POS_MINUTES = 2'd2;
  localparam logic [POS_W-1:0] POS_SECONDS = 2'd3;

  localparam logic [PERIOD_W-1:0] BLINK_PERIOD_RST  = 10'd200;
  localparam logic [PERIOD_W-1:0] HOLD_DELAY_RST    = 10'd300;
  localparam logic [PERIOD_W-1:0] REPEAT_PERIOD_RST = 10'd100;

  localparam logic [HOLD_W-1:0] HOLD_MAX  = 11'd2047;
  localparam logic [MIN_W-1:0]  HOURS_MAX = 6'd23;
  localparam logic [MIN_W-1:0]  MIN_MAX   = 6'd59;

  localparam logic [5:0] MASK_ALL     = 6'h3F;
  localparam logic [5:0] MASK_HOURS   = 6'h3C;
  localparam logic [5:0] MASK_MINUTES = 6'h33;
  localparam logic [5:0] MASK_SECONDS = 6'h0F;

  typedef struct packed {
    logic [1:0] hour_tens;
    logic [3:0] hour_units;
    logic [2:0] minute_tens;
    logic [3:0] minute_units;
    logic [2:0] second_tens;
    logic [3:0] second_units;
    logic [5:0] digit_enable;
    logic       dot_on;
    logic       rtc_write;
    logic       in_menu;
    logic [1:0] edit_position;
  } result_t;

  function automatic logic [MIN_W-1:0] inc_wrap(input logic [MIN_W-1:0] v,
                                                input logic [MIN_W-1:0] max);
    return (v >= max) ? '0 : v + 6'd1;
  endfunction

  function automatic logic [MIN_W-1:0] dec_wrap(input logic [MIN_W-1:0] v,
                                                input logic [MIN_W-1:0] max);
    return (v == '0) ? max : v - 6'd1;
  endfunction

  // tens digit of a value below 64
  function automatic logic [2:0] tens_of(input logic [MIN_W-1:0] v);
    logic [2:0] t;
    if (v >= 6'd60)      t = 3'd6;
    else if (v >= 6'd50) t = 3'd5;
    else if (v >= 6'd40) t = 3'd4;
    else if (v >= 6'd30) t = 3'd3;
    else if (v >= 6'd20) t = 3'd2;
    else if (v >= 6'd10) t = 3'd1;
    else                 t = 3'd0;
    return t;
  endfunction

  function automatic logic [3:0] units_of(input logic [MIN_W-1:0] v);
    logic [6:0] tens10;
    logic [6:0] diff;
    tens10 = {1'b0, tens_of(v), 3'b000} + {3'b000, tens_of(v), 1'b0};
    diff   = {1'b0, v} - tens10;
    return diff[3:0];
  endfunction

  // packed BCD to binary, saturated at max
  function automatic logic [MIN_W-1:0] bcd_sat(input logic [2:0] tens,
                                               input logic [3:0] units,
                                               input logic [MIN_W-1:0] max);
    logic [6:0] d;
    d = {1'b0, tens, 3'b000} + {3'b000, tens, 1'b0} + {3'b000, units};
    return (d > {1'b0, max}) ? max : d[MIN_W-1:0];
  endfunction

endpackage

// ----- sv/ctsc_req_if.sv -----
// ----------------------------------------------------------------------------
// ctsc_req_if
// Event channel: one transaction is one tick, click or pulse edge.
// ----------------------------------------------------------------------------
interface ctsc_req_if;
  import ctsc_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic                up_held;
  logic                down_held;
  logic                pulse_level;
  logic [6:0]          rtc_seconds_bcd;
  logic [6:0]          rtc_minutes_bcd;
  logic [5:0]          rtc_hours_bcd;

  modport source (output valid, opcode, up_held, down_held, pulse_level,
                  rtc_seconds_bcd, rtc_minutes_bcd, rtc_hours_bcd,
                  input ready);
  modport sink (input valid, opcode, up_held, down_held, pulse_level,
                rtc_seconds_bcd, rtc_minutes_bcd, rtc_hours_bcd,
                output ready);
endinterface

// ----- sv/ctsc_res_if.sv -----
// ----------------------------------------------------------------------------
// ctsc_res_if
// Display channel: one transaction per accepted event.
// ----------------------------------------------------------------------------
interface ctsc_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] hour_tens;
  logic [3:0] hour_units;
  logic [2:0] minute_tens;
  logic [3:0] minute_units;
  logic [2:0] second_tens;
  logic [3:0] second_units;
  logic [5:0] digit_enable;
  logic       dot_on;
  logic       rtc_write;
  logic       in_menu;
  logic [1:0] edit_position;

  modport source (output valid, hour_tens, hour_units, minute_tens, minute_units,
                  second_tens, second_units, digit_enable, dot_on, rtc_write,
                  in_menu, edit_position,
                  input ready);
  modport sink (input valid, hour_tens, hour_units, minute_tens, minute_units,
                second_tens, second_units, digit_enable, dot_on, rtc_write,
                in_menu, edit_position,
                output ready);
endinterface

// ----- sv/ctsc_cfg_if.sv -----
// ----------------------------------------------------------------------------
// ctsc_cfg_if
// Register write channel: index and data per transaction.
// ----------------------------------------------------------------------------
interface ctsc_cfg_if;
  import ctsc_pkg::*;

  logic                valid;
  logic                ready;
  logic [INDEX_W-1:0]  index;
  logic [PERIOD_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/clock_time_set_controller.sv -----
// ----------------------------------------------------------------------------
// clock_time_set_controller
// Time-setting menu of a six-digit clock: edit position, wrap adjust,
// auto-repeat, blinking of the edited pair, dot and RTC reload.
// ----------------------------------------------------------------------------
// Channels: request carries events (tick with held buttons and RTC time,
// OK/UP/DOWN clicks, pulse edges), result carries one display transaction
// per event, cfg writes blink_period (0), hold_delay (1) and
// repeat_period (2); other indexes are ignored. cfg is always ready.
// Latency: the result of an event is valid the cycle after it is accepted.
// Throughput: one event per cycle while result.ready is high; the state
// update is a single combinational pass between state and result registers.
// Stall: request.ready follows result.ready while a result is pending, so
// the block keeps taking events while the result register drains and
// holds off only when an unread result would be overwritten.
// Reset: clears the menu, time, counters and dot, lights all digits and
// loads the registers with 200, 300 and 100; no result is pending.
// ----------------------------------------------------------------------------
module clock_time_set_controller (
  input  logic          clk,
  input  logic          rst,
  ctsc_req_if.sink      request,
  ctsc_res_if.source    result,
  ctsc_cfg_if.sink      cfg
);
  import ctsc_pkg::*;

  logic [PERIOD_W-1:0] blink_period, hold_delay, repeat_period;

  logic                menu_active, menu_active_next;
  logic [POS_W-1:0]    position, position_next;
  logic [HOURS_W-1:0]  hours, hours_next;
  logic [MIN_W-1:0]    minutes, minutes_next;
  logic [MIN_W-1:0]    seconds_now, seconds_now_next;
  logic [PERIOD_W-1:0] blink_count, blink_count_next;
  logic                blink_phase, blink_phase_next;
  logic [HOLD_W-1:0]   hold_count, hold_count_next;
  logic [PERIOD_W-1:0] repeat_count, repeat_count_next;
  logic                reload_armed, reload_armed_next;
  logic                dot_state, dot_state_next;
  logic [5:0]          enable_mask, enable_mask_next;
  logic                wr_next;

  logic                out_valid;
  result_t             out_q;
  result_t             res_next;

  logic                accept;
  logic                step_en, step_up;
  logic                held;
  logic [1:0]          b;
  logic [PERIOD_W-1:0] blink_inc, repeat_inc;
  logic [MIN_W-1:0]    hours_ext;

  assign request.ready = !out_valid || result.ready;
  assign accept        = request.valid && request.ready;
  assign cfg.ready     = 1'b1;
  assign held          = request.up_held || request.down_held;
  assign blink_inc     = blink_count + 10'd1;
  assign repeat_inc    = repeat_count + 10'd1;
  assign hours_ext     = {1'b0, hours};

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_period  <= BLINK_PERIOD_RST;
      hold_delay    <= HOLD_DELAY_RST;
      repeat_period <= REPEAT_PERIOD_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_BLINK_PERIOD:  blink_period  <= cfg.data;
        REG_HOLD_DELAY:    hold_delay    <= cfg.data;
        REG_REPEAT_PERIOD: repeat_period <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    menu_active_next  = menu_active;
    position_next     = position;
    hours_next        = hours;
    minutes_next      = minutes;
    seconds_now_next  = seconds_now;
    blink_count_next  = blink_count;
    blink_phase_next  = blink_phase;
    hold_count_next   = hold_count;
    repeat_count_next = repeat_count;
    reload_armed_next = reload_armed;
    dot_state_next    = dot_state;
    enable_mask_next  = enable_mask;
    wr_next           = 1'b0;
    step_en           = 1'b0;
    step_up           = 1'b0;
    b                 = 2'b00;

    unique case (request.opcode)
      OP_TICK: begin
        if (menu_active) begin
          dot_state_next = 1'b0;
          if (!held) begin
            blink_count_next = blink_inc;
            if (blink_inc >= blink_period) begin
              blink_count_next = '0;
              blink_phase_next = !blink_phase;
            end
          end
          b = {2{blink_phase_next}};
          unique case (position)
            POS_HOURS:   enable_mask_next = MASK_HOURS | {4'b0000, b};
            POS_MINUTES: enable_mask_next = MASK_MINUTES | {2'b00, b, 2'b00};
            POS_SECONDS: enable_mask_next = MASK_SECONDS | {b, 4'b0000};
            default: ;
          endcase
          if (held) begin
            if (hold_count > {1'b0, hold_delay}) begin
              repeat_count_next = repeat_inc;
              if (repeat_inc >= repeat_period) begin
                repeat_count_next = '0;
                step_en = 1'b1;
                step_up = request.up_held;
              end
            end
            if (hold_count < HOLD_MAX) hold_count_next = hold_count + 11'd1;
          end else begin
            hold_count_next = '0;
          end
        end else if (reload_armed) begin
          reload_armed_next = 1'b0;
          seconds_now_next = bcd_sat(request.rtc_seconds_bcd[6:4],
                                     request.rtc_seconds_bcd[3:0], MIN_MAX);
          minutes_next = bcd_sat(request.rtc_minutes_bcd[6:4],
                                 request.rtc_minutes_bcd[3:0], MIN_MAX);
          hours_next = HOURS_W'(bcd_sat({1'b0, request.rtc_hours_bcd[5:4]},
                                        request.rtc_hours_bcd[3:0], HOURS_MAX));
        end
      end
      OP_OK: begin
        menu_active_next = 1'b1;
        if (position == POS_SECONDS) begin
          menu_active_next = 1'b0;
          blink_count_next = '0;
          position_next    = POS_NONE;
          enable_mask_next = MASK_ALL;
          wr_next          = 1'b1;
        end else begin
          position_next = position + 2'd1;
        end
      end
      OP_UP, OP_DOWN: begin
        blink_count_next = '0;
        blink_phase_next = 1'b1;
        step_en          = 1'b1;
        step_up          = (request.opcode == OP_UP);
      end
      OP_PULSE: begin
        if (!menu_active) begin
          dot_state_next = request.pulse_level;
          if (request.pulse_level) reload_armed_next = 1'b1;
        end
      end
      default: ;
    endcase

    if (step_en) begin
      unique case (position)
        POS_HOURS: hours_next = step_up ? HOURS_W'(inc_wrap(hours_ext, HOURS_MAX))
                                        : HOURS_W'(dec_wrap(hours_ext, HOURS_MAX));
        POS_MINUTES: minutes_next = step_up ? inc_wrap(minutes, MIN_MAX)
                                            : dec_wrap(minutes, MIN_MAX);
        POS_SECONDS: seconds_now_next = step_up ? inc_wrap(seconds_now, MIN_MAX)
                                                : dec_wrap(seconds_now, MIN_MAX);
        default: ;
      endcase
    end
  end

  always_comb begin
    res_next.hour_tens     = 2'(tens_of({1'b0, hours_next}));
    res_next.hour_units    = units_of({1'b0, hours_next});
    res_next.minute_tens   = tens_of(minutes_next);
    res_next.minute_units  = units_of(minutes_next);
    res_next.second_tens   = tens_of(seconds_now_next);
    res_next.second_units  = units_of(seconds_now_next);
    res_next.digit_enable  = enable_mask_next;
    res_next.dot_on        = dot_state_next;
    res_next.rtc_write     = wr_next;
    res_next.in_menu       = menu_active_next;
    res_next.edit_position = position_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      menu_active  <= 1'b0;
      position     <= POS_NONE;
      hours        <= '0;
      minutes      <= '0;
      seconds_now  <= '0;
      blink_count  <= '0;
      blink_phase  <= 1'b0;
      hold_count   <= '0;
      repeat_count <= '0;
      reload_armed <= 1'b0;
      dot_state    <= 1'b0;
      enable_mask  <= MASK_ALL;
    end else if (accept) begin
      menu_active  <= menu_active_next;
      position     <= position_next;
      hours        <= hours_next;
      minutes      <= minutes_next;
      seconds_now  <= seconds_now_next;
      blink_count  <= blink_count_next;
      blink_phase  <= blink_phase_next;
      hold_count   <= hold_count_next;
      repeat_count <= repeat_count_next;
      reload_armed <= reload_armed_next;
      dot_state    <= dot_state_next;
      enable_mask  <= enable_mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_q <= res_next;
  end

  assign result.valid         = out_valid;
  assign result.hour_tens     = out_q.hour_tens;
  assign result.hour_units    = out_q.hour_units;
  assign result.minute_tens   = out_q.minute_tens;
  assign result.minute_units  = out_q.minute_units;
  assign result.second_tens   = out_q.second_tens;
  assign result.second_units  = out_q.second_units;
  assign result.digit_enable  = out_q.digit_enable;
  assign result.dot_on        = out_q.dot_on;
  assign result.rtc_write     = out_q.rtc_write;
  assign result.in_menu       = out_q.in_menu;
  assign result.edit_position = out_q.edit_position;

endmodule

// ----- dv/clock_time_set_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clock_time_set_checker
// Watches the event, display and register channels of the clock time-set
// controller. Every accepted event updates a local model of the menu, the
// time and the counters. The display transaction that the event should cause
// is queued, and each display transaction taken from the block is compared
// with the oldest one in the queue.
// ----------------------------------------------------------------------------
module clock_time_set_checker (
  input  logic clk,
  input  logic rst,
  ctsc_req_if  req,
  ctsc_res_if  res,
  ctsc_cfg_if  cfg,
  output int   errors,
  output int   pending
);
  import ctsc_pkg::*;

  logic [PERIOD_W-1:0] blink_period;
  logic [PERIOD_W-1:0] hold_delay;
  logic [PERIOD_W-1:0] repeat_period;

  logic                menu_on;
  logic [POS_W-1:0]    pos;
  logic [HOURS_W-1:0]  hours;
  logic [MIN_W-1:0]    minutes;
  logic [MIN_W-1:0]    seconds;
  logic [PERIOD_W-1:0] blink_cnt;
  logic                blink_on;
  logic [HOLD_W-1:0]   hold_cnt;
  logic [PERIOD_W-1:0] repeat_cnt;
  logic                reload_armed;
  logic                dot;
  logic [5:0]          en_mask;

  result_t             expected_displays[$];
  result_t             got;
  result_t             want;
  int                  n_err;

  function automatic logic [MIN_W-1:0] bcd_to_bin(input logic [3:0] tens,
                                                  input logic [3:0] units,
                                                  input logic [MIN_W-1:0] max_val);
    int d;
    d = tens * 10 + units;
    return (d > max_val) ? max_val : d[MIN_W-1:0];
  endfunction

  function automatic void adjust_field(input logic up);
    case (pos)
      POS_HOURS:
        if (up) hours = (hours >= HOURS_MAX) ? '0 : hours + 1'b1;
        else    hours = (hours == '0) ? HOURS_MAX[HOURS_W-1:0] : hours - 1'b1;
      POS_MINUTES:
        if (up) minutes = (minutes >= MIN_MAX) ? '0 : minutes + 1'b1;
        else    minutes = (minutes == '0) ? MIN_MAX : minutes - 1'b1;
      POS_SECONDS:
        if (up) seconds = (seconds >= MIN_MAX) ? '0 : seconds + 1'b1;
        else    seconds = (seconds == '0) ? MIN_MAX : seconds - 1'b1;
      default: ;
    endcase
  endfunction

  function automatic void menu_tick(input logic up, input logic down);
    logic [1:0] b;
    dot = 1'b0;
    if (!up && !down) begin
      blink_cnt = blink_cnt + 1'b1;
      if (blink_cnt >= blink_period) begin
        blink_cnt = '0;
        blink_on  = !blink_on;
      end
    end
    b = {2{blink_on}};
    case (pos)
      POS_HOURS:   en_mask = MASK_HOURS | {4'b0000, b};
      POS_MINUTES: en_mask = MASK_MINUTES | {2'b00, b, 2'b00};
      POS_SECONDS: en_mask = MASK_SECONDS | {b, 4'b0000};
      default: ;
    endcase
    if (up || down) begin
      if (hold_cnt > hold_delay) begin
        repeat_cnt = repeat_cnt + 1'b1;
        if (repeat_cnt >= repeat_period) begin
          repeat_cnt = '0;
          adjust_field(up);
        end
      end
      if (hold_cnt < HOLD_MAX) hold_cnt = hold_cnt + 1'b1;
    end else begin
      hold_cnt = '0;
    end
  endfunction

  function automatic result_t apply_event(input logic [OPCODE_W-1:0] op,
                                          input logic up, input logic down,
                                          input logic level,
                                          input logic [6:0] sec_bcd,
                                          input logic [6:0] min_bcd,
                                          input logic [5:0] hr_bcd);
    result_t r;
    logic    wr;
    wr = 1'b0;
    case (op)
      OP_TICK:
        if (menu_on) begin
          menu_tick(up, down);
        end else if (reload_armed) begin
          reload_armed = 1'b0;
          seconds = bcd_to_bin({1'b0, sec_bcd[6:4]}, sec_bcd[3:0], MIN_MAX);
          minutes = bcd_to_bin({1'b0, min_bcd[6:4]}, min_bcd[3:0], MIN_MAX);
          hours   = HOURS_W'(bcd_to_bin({2'b00, hr_bcd[5:4]}, hr_bcd[3:0], HOURS_MAX));
        end
      OP_OK: begin
        menu_on = 1'b1;
        if (pos == POS_SECONDS) begin
          menu_on   = 1'b0;
          blink_cnt = '0;
          pos       = POS_NONE;
          en_mask   = MASK_ALL;
          wr        = 1'b1;
        end else begin
          pos = pos + 1'b1;
        end
      end
      OP_UP, OP_DOWN: begin
        blink_cnt = '0;
        blink_on  = 1'b1;
        adjust_field(op == OP_UP);
      end
      OP_PULSE:
        if (!menu_on) begin
          dot = level;
          if (level) reload_armed = 1'b1;
        end
      default: ;
    endcase
    r.hour_tens     = 2'(hours / 10);
    r.hour_units    = 4'(hours % 10);
    r.minute_tens   = 3'(minutes / 10);
    r.minute_units  = 4'(minutes % 10);
    r.second_tens   = 3'(seconds / 10);
    r.second_units  = 4'(seconds % 10);
    r.digit_enable  = en_mask;
    r.dot_on        = dot;
    r.rtc_write     = wr;
    r.in_menu       = menu_on;
    r.edit_position = pos;
    return r;
  endfunction

  function automatic string show(input result_t r);
    return $sformatf("%0d%0d:%0d%0d:%0d%0d en=%b dot=%b wr=%b menu=%b pos=%0d",
                     r.hour_tens, r.hour_units, r.minute_tens, r.minute_units,
                     r.second_tens, r.second_units, r.digit_enable, r.dot_on,
                     r.rtc_write, r.in_menu, r.edit_position);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      blink_period  = BLINK_PERIOD_RST;
      hold_delay    = HOLD_DELAY_RST;
      repeat_period = REPEAT_PERIOD_RST;
      menu_on       = 1'b0;
      pos           = POS_NONE;
      hours         = '0;
      minutes       = '0;
      seconds       = '0;
      blink_cnt     = '0;
      blink_on      = 1'b0;
      hold_cnt      = '0;
      repeat_cnt    = '0;
      reload_armed  = 1'b0;
      dot           = 1'b0;
      en_mask       = MASK_ALL;
      n_err         = 0;
      expected_displays.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_BLINK_PERIOD:  blink_period  = cfg.data;
          REG_HOLD_DELAY:    hold_delay    = cfg.data;
          REG_REPEAT_PERIOD: repeat_period = cfg.data;
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        expected_displays.push_back(apply_event(req.opcode, req.up_held, req.down_held,
                                                req.pulse_level, req.rtc_seconds_bcd,
                                                req.rtc_minutes_bcd, req.rtc_hours_bcd));
      end
      if (res.valid && res.ready) begin
        got = {res.hour_tens, res.hour_units, res.minute_tens, res.minute_units,
               res.second_tens, res.second_units, res.digit_enable, res.dot_on,
               res.rtc_write, res.in_menu, res.edit_position};
        if (expected_displays.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("%0t: unexpected display transaction %s", $realtime,
                                    show(got));
        end else begin
          want = expected_displays.pop_front();
          if (got !== want) begin
            n_err++;
            if (n_err <= 10) $display("%0t: display mismatch, expected %s, got %s",
                                      $realtime, show(want), show(got));
          end
        end
      end
    end
    errors  <= n_err;
    pending <= expected_displays.size();
  end

endmodule

// ----- dv/clock_time_set_controller_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clock_time_set_controller_tb
// Drives the clock time-set controller with directed events, a long held
// button run well past the hold delay, and random menu, reload and
// noise sequences under several register settings. Events come in bursts,
// the display side stalls on its own pattern, and a checker beside the
// block predicts and compares every display transaction.
// ----------------------------------------------------------------------------
module clock_time_set_controller_tb;
  import ctsc_pkg::*;

  localparam int unsigned CLK_HIGH_NS     = 4;
  localparam int unsigned CLK_LOW_NS      = 4;
  localparam int unsigned RESET_CYCLES    = 5;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned LONG_HOLD_TICKS = 400;
  localparam int unsigned PHASE_EVENTS    = 150;
  localparam int unsigned LIMIT_NS        = 5_000_000;

  localparam logic [OPCODE_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_HI = 3'd7;
  localparam logic [INDEX_W-1:0]  REG_UNUSED   = 2'd3;

  logic        clk = 1'b0;
  logic        rst;
  int          errors;
  int          pending;
  int          burst_left;
  int unsigned events_sent;

  ctsc_req_if req_ch ();
  ctsc_res_if res_ch ();
  ctsc_cfg_if cfg_ch ();

  clock_time_set_controller DUT (
    .clk     (clk),
    .rst     (rst),
    .request (req_ch),
    .result  (res_ch),
    .cfg     (cfg_ch)
  );

  clock_time_set_checker display_check (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .res     (res_ch),
    .cfg     (cfg_ch),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    #CLK_HIGH_NS clk = 1'b1;
    #CLK_LOW_NS  clk = 1'b0;
  end

  task automatic send_event(input logic [OPCODE_W-1:0] op, input logic up,
                            input logic down, input logic level,
                            input logic [6:0] sec, input logic [6:0] min,
                            input logic [5:0] hr);
    req_ch.valid           <= 1'b1;
    req_ch.opcode          <= op;
    req_ch.up_held         <= up;
    req_ch.down_held       <= down;
    req_ch.pulse_level     <= level;
    req_ch.rtc_seconds_bcd <= sec;
    req_ch.rtc_minutes_bcd <= min;
    req_ch.rtc_hours_bcd   <= hr;
    do @(posedge clk); while (!req_ch.ready);
    events_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
    end
  endtask

  task automatic send_op(input logic [OPCODE_W-1:0] op);
    send_event(op, 1'($urandom), 1'($urandom), 1'($urandom), 7'($urandom),
               7'($urandom), 6'($urandom));
  endtask

  task automatic send_tick(input logic up, input logic down);
    send_event(OP_TICK, up, down, 1'($urandom), 7'($urandom), 7'($urandom),
               6'($urandom));
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [INDEX_W-1:0] idx, input logic [PERIOD_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic write_regs(input logic [PERIOD_W-1:0] blink, input logic [PERIOD_W-1:0] hold,
                            input logic [PERIOD_W-1:0] rep);
    cfg_put(REG_UNUSED, PERIOD_W'($urandom));
    cfg_put(REG_BLINK_PERIOD, blink);
    cfg_put(REG_HOLD_DELAY, hold);
    cfg_put(REG_REPEAT_PERIOD, rep);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic menu_session();
    logic [1:0] held;
    int         run;
    send_op(OP_OK);
    repeat (3) begin
      repeat ($urandom_range(0, 5)) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            held = 2'($urandom_range(0, 3));
            run  = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 120)
                                                : $urandom_range(1, 20);
            repeat (run) send_tick(held[1], held[0]);
          end
          4, 5:    send_op(OP_UP);
          6, 7:    send_op(OP_DOWN);
          8:       send_op(OP_PULSE);
          default: send_op(OPCODE_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)));
        endcase
      end
      send_op(OP_OK);
    end
  endtask

  task automatic reload_session();
    logic [6:0] sec_v;
    logic [6:0] min_v;
    logic [5:0] hr_v;
    if ($urandom_range(0, 1)) begin
      sec_v = 7'($urandom_range(0, 5) * 16 + $urandom_range(0, 9));
      min_v = 7'($urandom_range(0, 5) * 16 + $urandom_range(0, 9));
      hr_v  = 6'($urandom_range(0, 2) * 16 + $urandom_range(0, 9));
    end else begin
      sec_v = 7'($urandom);
      min_v = 7'($urandom);
      hr_v  = 6'($urandom);
    end
    if ($urandom_range(0, 3) == 0) send_op(OP_PULSE);
    send_event(OP_PULSE, 1'($urandom), 1'($urandom), 1'b1, 7'($urandom), 7'($urandom),
               6'($urandom));
    if ($urandom_range(0, 3) == 0)
      send_event(OP_PULSE, 1'($urandom), 1'($urandom), 1'b0, 7'($urandom), 7'($urandom),
                 6'($urandom));
    send_event(OP_TICK, 1'($urandom), 1'($urandom), 1'($urandom), sec_v, min_v, hr_v);
    repeat ($urandom_range(0, 3)) send_op(OP_TICK);
  endtask

  task automatic random_phase(input int unsigned count);
    int unsigned stop_at;
    stop_at = events_sent + count;
    while (events_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: menu_session();
        5, 6, 7:       reload_session();
        default:       repeat ($urandom_range(1, 6))
                         send_op(OPCODE_W'($urandom_range(OP_TICK, OP_UNUSED_HI)));
      endcase
    end
  endtask

  initial begin
    logic [1:0] held;
    rst                    <= 1'b1;
    req_ch.valid           <= 1'b0;
    req_ch.opcode          <= OP_TICK;
    req_ch.up_held         <= 1'b0;
    req_ch.down_held       <= 1'b0;
    req_ch.pulse_level     <= 1'b0;
    req_ch.rtc_seconds_bcd <= '0;
    req_ch.rtc_minutes_bcd <= '0;
    req_ch.rtc_hours_bcd   <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.index           <= REG_BLINK_PERIOD;
    cfg_ch.data            <= '0;
    burst_left  = $urandom_range(1, 12);
    events_sent = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset settings: reload, bad BCD, clicks outside the menu, unused opcodes
    send_event(OP_TICK, 1'b0, 1'b0, 1'b0, 7'h00, 7'h00, 6'h00);
    send_event(OP_PULSE, 1'b0, 1'b0, 1'b1, 7'h00, 7'h00, 6'h00);
    send_event(OP_TICK, 1'b0, 1'b0, 1'b0, 7'h59, 7'h59, 6'h23);
    send_event(OP_PULSE, 1'b0, 1'b0, 1'b0, 7'h7F, 7'h7F, 6'h3F);
    send_event(OP_PULSE, 1'b1, 1'b1, 1'b1, 7'h7F, 7'h7F, 6'h3F);
    send_event(OP_TICK, 1'b1, 1'b1, 1'b1, 7'h7F, 7'h7F, 6'h3F);
    send_event(OP_UP, 1'b0, 1'b0, 1'b0, 7'h00, 7'h00, 6'h00);
    send_event(OP_DOWN, 1'b1, 1'b1, 1'b1, 7'h7F, 7'h7F, 6'h3F);
    send_event(OP_UNUSED_LO, 1'b1, 1'b0, 1'b1, 7'h2A, 7'h55, 6'h15);
    send_event(OP_UNUSED_HI, 1'b0, 1'b1, 1'b0, 7'h55, 7'h2A, 6'h2A);
    send_event(OP_PULSE, 1'b0, 1'b0, 1'b1, 7'h00, 7'h00, 6'h00);
    send_event(OP_TICK, 1'b0, 1'b0, 1'b0, 7'h00, 7'h00, 6'h00);

    // zero periods: blink and repeat act on every qualifying tick
    wait_drained();
    write_regs('0, '0, '0);
    send_op(OP_OK);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_op(OP_DOWN);
    send_op(OP_UP);
    send_op(OP_OK);
    send_op(OP_DOWN);
    send_op(OP_OK);
    send_event(OP_PULSE, 1'b0, 1'b0, 1'b1, 7'h00, 7'h00, 6'h00);
    send_op(OP_UP);
    send_op(OP_OK);

    // long hold: auto-repeat starts after the hold delay and keeps stepping
    wait_drained();
    write_regs(10'd5, 10'd200, 10'd3);
    send_op(OP_OK);
    repeat (LONG_HOLD_TICKS) begin
      held = 2'($urandom_range(1, 3));
      send_tick(held[1], held[0]);
    end
    repeat (3) send_op(OP_OK);

    wait_drained();
    write_regs(10'd1, 10'd0, 10'd1);
    random_phase(PHASE_EVENTS);

    wait_drained();
    write_regs(10'd1023, 10'd1023, 10'd1023);
    random_phase(PHASE_EVENTS);

    repeat (2) begin
      wait_drained();
      write_regs(PERIOD_W'($urandom_range(1, 16)), PERIOD_W'($urandom_range(0, 24)),
                 PERIOD_W'($urandom_range(1, 8)));
      random_phase(PHASE_EVENTS);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    int seg_len;
    int mode;
    res_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    // long hold-off while events keep coming, so the block backs up
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    forever begin
      mode    = $urandom_range(0, 15);
      seg_len = (mode == 0) ? $urandom_range(100, 300) : $urandom_range(5, 80);
      repeat (seg_len) begin
        if (mode == 0)      res_ch.ready <= 1'b0;
        else if (mode < 6)  res_ch.ready <= 1'b1;
        else if (mode < 11) res_ch.ready <= 1'($urandom_range(0, 1));
        else                res_ch.ready <= ($urandom_range(0, 3) == 0);
        @(posedge clk);
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- clock_time_set_controller.f -----
sv/ctsc_pkg.sv
sv/ctsc_req_if.sv
sv/ctsc_res_if.sv
sv/ctsc_cfg_if.sv
sv/clock_time_set_controller.sv
dv/clock_time_set_checker.sv
dv/clock_time_set_controller_tb.sv
